/* src/nand_bad_block_skip_mapper_defines.svh */
// Assertion macros for the checker of the bad-block skip mapper.
`ifndef NAND_BAD_BLOCK_SKIP_MAPPER_DEFINES_SVH
`define NAND_BAD_BLOCK_SKIP_MAPPER_DEFINES_SVH

// Clocked assertion, switched off while reset is held low.
`define NBBSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nbbsm assertion failed");

// Clocked assertion that also holds across reset.
`define NBBSM_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nbbsm reset assertion failed");

`endif

/* src/nbbsm_pkg.sv */
// Types, constants and helpers shared by the bad-block skip mapper modules.
package nbbsm_pkg;

    // Flash geometry
    localparam int unsigned SECTORS_PER_PAGE = 4;
    localparam int unsigned PAGES_PER_BLOCK  = 64;
    localparam int unsigned BLOCK_COUNT      = 4096;
    localparam int unsigned SEC_SHIFT        = $clog2(SECTORS_PER_PAGE);
    localparam int unsigned PG_SHIFT         = $clog2(PAGES_PER_BLOCK);

    // Field widths
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned IDXIN_W = 5;
    localparam int unsigned ENTRY_W = 12;
    localparam int unsigned SADDR_W = 20;
    localparam int unsigned CNT_W   = 12;
    localparam int unsigned BASE_W  = 8;
    localparam int unsigned PAGE_W  = 6;
    localparam int unsigned SECP_W  = 2;
    localparam int unsigned SUM_W   = SADDR_W + 1;
    localparam int unsigned BLK_W   = SUM_W - SEC_SHIFT - PG_SHIFT;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [BASE_W-1:0] BASE_RESET = 8'd1;
    localparam int unsigned       BLK_MAX    = 4095;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_XLATE = 2'd1,
        ACT_FIND  = 2'd2
    } t_action;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic count_step;
        logic walk_step;
        logic skip_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_entry;
        logic n_zero;
        logic cur_bad;
        logic out_free;
    } t_dp_stat;

    function automatic logic over_flag(input logic [BLK_W-1:0] blk);
        return (32'(blk) >= BLOCK_COUNT) || (32'(blk) > BLK_MAX);
    endfunction

endpackage

/* src/nbbsm_ctrl.sv */
// Sequencer for the bad-block skip mapper: count, walk, skip and result hand-off.
module nbbsm_ctrl
    import nbbsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [ACT_W-1:0]  i_action,
    output logic              o_ready,
    output t_dp_cmd           o_cmd,
    input  t_dp_stat          i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_PASS,
        S_SKIP,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_action r_act;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    case (t_action'(i_action))
                        ACT_XLATE: n_state = S_COUNT;
                        ACT_FIND:  n_state = S_PASS;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_COUNT: begin
                o_cmd.count_step = 1'b1;
                if (i_stat.last_entry) begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (i_stat.n_zero) begin
                    n_state = (r_act == ACT_XLATE) ? S_SKIP : S_DONE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_SKIP: begin
                if (i_stat.cur_bad) begin
                    o_cmd.skip_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_LOAD;
        end else begin
            r_state <= n_state;
            if (o_cmd.capture) begin
                r_act <= t_action'(i_action);
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

/* src/nbbsm_dp.sv */
// Datapath: bad list, comparator bank, block walker and result register.
module nbbsm_dp
    import nbbsm_pkg::*;
#(
    parameter int unsigned BAD_LIST_DEPTH = 32
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_wr_en,
    input  logic [BASE_W-1:0]     i_cfg_wr_data,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [IN_DATA_W-1:0]  i_data,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic                  o_m_user
);

    localparam int unsigned IDX_W = (BAD_LIST_DEPTH > 1) ? $clog2(BAD_LIST_DEPTH) : 1;

    logic [ENTRY_W-1:0] r_list [BAD_LIST_DEPTH];
    logic [BASE_W-1:0]  r_base;
    logic [BLK_W-1:0]   r_cur;
    logic [CNT_W-1:0]   r_n;
    logic [IDX_W-1:0]   r_idx;
    logic [PAGE_W-1:0]  r_page;
    logic [SECP_W-1:0]  r_sec;
    t_action            r_act;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               r_out_ovf;

    logic [IDXIN_W-1:0] in_idx;
    logic [ENTRY_W-1:0] in_val;
    logic [SADDR_W-1:0] in_saddr;
    logic [CNT_W-1:0]   in_gc;
    logic [SUM_W-1:0]   sum;
    logic [BLK_W-1:0]   probe;
    logic [ENTRY_W-1:0] cur_entry;
    logic               hit;
    logic               in_range;
    logic [BLK_W-1:0]   res_blk;
    logic               res_ovf;

    assign in_idx   = i_data[IDXIN_W-1:0];
    assign in_val   = i_data[IDXIN_W +: ENTRY_W];
    assign in_saddr = i_data[IDXIN_W+ENTRY_W +: SADDR_W];
    assign in_gc    = i_data[IDXIN_W+ENTRY_W+SADDR_W +: CNT_W];

    // Logical sector plus image base in sectors
    assign sum = SUM_W'(in_saddr) + (SUM_W'(r_base) << (SEC_SHIFT + PG_SHIFT));

    // Comparator bank: during the count pass look for an earlier copy of the
    // current entry, otherwise test the walk position against every entry.
    assign cur_entry = r_list[r_idx];
    assign probe     = i_cmd.count_step ? BLK_W'(cur_entry) : r_cur;

    always_comb begin
        hit = 1'b0;
        for (int j = 0; j < int'(BAD_LIST_DEPTH); j++) begin
            if ((!i_cmd.count_step || (j < int'(r_idx)))
                    && (BLK_W'(r_list[j]) == probe)) begin
                hit = 1'b1;
            end
        end
    end

    assign in_range = (cur_entry >= ENTRY_W'(r_base)) && (BLK_W'(cur_entry) < r_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < int'(BAD_LIST_DEPTH); k++) begin
                r_list[k] <= '0;
            end
        end else if (i_cmd.capture && (t_action'(i_action) == ACT_LOAD)
                && (32'(in_idx) < BAD_LIST_DEPTH)) begin
            r_list[IDX_W'(in_idx)] <= in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= t_action'(i_action);
            r_idx  <= '0;
            r_page <= sum[SEC_SHIFT +: PAGE_W];
            r_sec  <= sum[SECP_W-1:0];
            if (t_action'(i_action) == ACT_FIND) begin
                r_cur <= BLK_W'(1);
                r_n   <= in_gc;
            end else begin
                r_cur <= sum[SUM_W-1 -: BLK_W];
                r_n   <= '0;
            end
        end else if (i_cmd.count_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (in_range && !hit) begin
                r_n <= r_n + CNT_W'(1);
            end
        end else if (i_cmd.walk_step) begin
            r_cur <= r_cur + BLK_W'(1);
            if (!hit) begin
                r_n <= r_n - CNT_W'(1);
            end
        end else if (i_cmd.skip_step) begin
            r_cur <= r_cur + BLK_W'(1);
        end
    end

    always_comb begin
        res_blk = (r_act == ACT_FIND) ? (r_cur - BLK_W'(1)) : r_cur;
        res_ovf = over_flag(res_blk);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (r_act)
                ACT_XLATE: begin
                    r_out_data <= {4'd0, r_sec, r_page, res_blk[ENTRY_W-1:0]};
                    r_out_ovf  <= res_ovf;
                end
                ACT_FIND: begin
                    r_out_data <= {4'd0, SECP_W'(0), PAGE_W'(0), res_blk[ENTRY_W-1:0]};
                    r_out_ovf  <= res_ovf;
                end
                default: begin
                    r_out_data <= '0;
                    r_out_ovf  <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_ovf;

    assign o_stat.last_entry = (r_idx == IDX_W'(BAD_LIST_DEPTH - 1));
    assign o_stat.n_zero     = (r_n == '0);
    assign o_stat.cur_bad    = hit;
    assign o_stat.out_free   = !r_out_valid || i_m_ready;

endmodule

/* src/nand_bad_block_skip_mapper.sv */
// Top level of the NAND bad-block skip mapper.
//
//  port group     dir  payload (lowest bit first)
//  s_axis_*       in   tuser: action; tdata: entry_index, block_value,
//                      sector_address, good_count
//  m_axis_*       out  tuser: overflow; tdata: phys_block, page_in_block,
//                      sector_in_page
//  i_cfg_wr_*     in   base_block
//
// One item at a time. Load or unused action: straight to the result hand-off. Translate: one
// scan step per list entry, then one step per block walked past (good blocks counted plus bad
// blocks skipped). Search: one block tested per cycle against the whole list, walking over
// good_count good blocks and the bad blocks passed. The input is ready again in the same cycle
// in which m_axis_tvalid rises, so the next item runs while a result may still wait in the
// output register; it then holds in its last state. Reset clears the list at once.
module nand_bad_block_skip_mapper
    import nbbsm_pkg::*;
#(
    parameter int unsigned BAD_LIST_DEPTH = 32
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index[4:0], block_value[16:5], sector_address[36:17],
    // good_count[48:37], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // phys_block[11:0], page_in_block[17:12], sector_in_page[19:18], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // overflow[0]
    output logic                  m_axis_tuser,
    // base_block register
    input  logic                  i_cfg_wr_en,
    input  logic [BASE_W-1:0]     i_cfg_wr_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each item through the count, walk and skip phases that its action needs
    nbbsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .o_cmd    (dp_cmd),
        .i_stat   (dp_stat)
    );

    // Hold the bad list, walk the block number and present the result
    nbbsm_dp #(
        .BAD_LIST_DEPTH (BAD_LIST_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_action      (s_axis_tuser),
        .i_data        (s_axis_tdata),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_data      (m_axis_tdata),
        .o_m_user      (m_axis_tuser)
    );

endmodule

/* src/nbbsm_chk.sv */
// Port-level checker for the bad-block skip mapper, bound to the top level.
`include "nand_bad_block_skip_mapper_defines.svh"

module nbbsm_chk
    import nbbsm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a result held back by the sink stays offered
    `NBBSM_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

    // and keeps its payload
    `NBBSM_ASSERT(a_out_stable, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // one item at a time: busy in the cycle after an accept
    `NBBSM_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

    // a fresh result appears only as the block returns to idle
    `NBBSM_ASSERT(a_result_then_idle, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> s_axis_tready)

    // reset empties the output register
    `NBBSM_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind nand_bad_block_skip_mapper nbbsm_chk u_nbbsm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
